// ===== sv/stack_calculator_engine_defines.svh =====
// Assertion macros shared by the stack calculator RTL.
`ifndef STACK_CALCULATOR_ENGINE_DEFINES_SVH
`define STACK_CALCULATOR_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Plain property, checked on every clock edge out of reset
`define SCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent this cycle, consequent on the next edge
`define SCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SCE_ASSERT(lbl, prop, msg)
`define SCE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/sce_pkg.sv =====
// Constants and types for the stack calculator engine.
`default_nettype none
package sce_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 32;

    localparam int DATA_W   = 64;
    localparam int HALF_W   = DATA_W / 2;
    localparam int WIDE_W   = 2 * DATA_W;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 7;
    localparam int PTR_W    = $clog2(STACK_DEPTH);
    localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
    // quotient bits that can be non-zero: magnitude shifted up by FRAC_BITS
    localparam int QUO_W    = DATA_W + FRAC_BITS;
    localparam int ITER_W   = $clog2(QUO_W);
    localparam int MUL_STEPS = 4;

    localparam logic [DATA_W-1:0] POS_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_LIMIT = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [KIND_W-1:0] {
        K_PUSH = 3'd0,
        K_ADD  = 3'd1,
        K_SUB  = 3'd2,
        K_MUL  = 3'd3,
        K_DIV  = 3'd4,
        K_NEG  = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

endpackage
`default_nettype wire

// ===== sv/sce_ram.sv =====
// Generic single write port RAM with one registered read port.
`default_nettype none
module sce_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/stack_calculator_engine.sv =====
// Top level of the RPN stack calculator: sequencer, shared arithmetic unit and stack RAM.
//
//   channel  direction  handshake             payload
//   cmd      in         cmd_valid / cmd_stall kind, immediate
//   res      out        res_valid / res_stall top_value, depth, status, saturated
//
// Push, negate, unused kinds, underflowing and halted items: decode, then output load.
// Add, subtract and divide by zero: decode, operand fetch, output load.
// Multiply: as add, with four 32x32 partial products through one multiplier and a finish.
// Divide: as multiply, but one quotient bit a cycle in the divider, QUO_W bits at Q32.32.
// cmd_stall is high from acceptance until the result is loaded into the output register;
// a result waiting on res_stall holds the sequencer before its output load.
// Reset clears the depth, the status and the sequencer; stack RAM contents are not cleared.
`default_nettype none
`include "stack_calculator_engine_defines.svh"
module stack_calculator_engine
    import sce_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_stall,
    input  wire logic [KIND_W-1:0]          kind,
    input  wire logic signed [DATA_W-1:0]   immediate,
    output logic                            res_valid,
    input  wire logic                       res_stall,
    output logic signed [DATA_W-1:0]        top_value,
    output logic [DEPTH_W-1:0]              depth,
    output logic [STATUS_W-1:0]             status,
    output logic                            saturated
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_MUL,
        S_DIV,
        S_FINISH,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [DATA_W-1:0]   imm_reg;
    logic [CNT_W-1:0]    count_reg;
    status_t             err_reg;
    logic [DATA_W-1:0]   top_reg;
    logic                sat_reg;
    logic [DATA_W-1:0]   opa_reg;
    logic [DATA_W-1:0]   opb_reg;
    logic                neg_reg;
    logic                is_div_reg;
    logic [WIDE_W-1:0]   work_reg;
    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   prod_reg;
    logic [1:0]          psh_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic                res_valid_reg;
    logic [DATA_W-1:0]   top_value_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                saturated_reg;

    logic                halted;
    logic [CNT_W-1:0]    cnt_m1;
    logic [CNT_W-1:0]    cnt_m2;

    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [PTR_W-1:0]    ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic [DATA_W-1:0]   add_a;
    logic [DATA_W-1:0]   add_bx;
    logic                add_sub;
    logic [DATA_W-1:0]   add_sum;
    logic                add_ovf;
    logic [DATA_W-1:0]   add_res;

    logic [DATA_W-1:0]   mag_a;
    logic [DATA_W-1:0]   mag_b;
    logic [DATA_W-1:0]   dz_val;

    logic [HALF_W-1:0]   pp_x;
    logic [HALF_W-1:0]   pp_y;
    logic [DATA_W-1:0]   pp_prod;
    logic [1:0]          pp_sh;
    logic [WIDE_W-1:0]   pp_wide;

    logic [DATA_W:0]     div_tmp;
    logic [DATA_W+1:0]   div_diff;
    logic                div_ge;
    logic [DATA_W-1:0]   div_rem_next;

    logic [WIDE_W-1:0]   fin_wide;
    logic                fin_hi_nz;
    logic [DATA_W-1:0]   fin_lo;
    logic                fin_sat;
    logic [DATA_W-1:0]   fin_val;

    assign halted = (err_reg == ST_UNDER);
    assign cnt_m1 = count_reg - CNT_W'(1);
    assign cnt_m2 = count_reg - CNT_W'(2);

    // shared saturating adder: negate in decode, add or subtract in fetch
    assign add_a   = (state_reg == S_FETCH) ? ram_rdata : '0;
    assign add_sub = (state_reg == S_FETCH) ? (kind_reg == K_SUB) : 1'b1;
    assign add_bx  = add_sub ? ~top_reg : top_reg;
    assign add_sum = add_a + add_bx + DATA_W'(add_sub);
    assign add_ovf = (add_a[DATA_W-1] == add_bx[DATA_W-1])
                     && (add_sum[DATA_W-1] != add_a[DATA_W-1]);
    assign add_res = add_ovf ? (add_a[DATA_W-1] ? NEG_LIMIT : POS_LIMIT) : add_sum;

    // operand magnitudes; a comes from RAM, b is the cached top
    assign mag_a  = ram_rdata[DATA_W-1] ? (DATA_W'(0) - ram_rdata) : ram_rdata;
    assign mag_b  = top_reg[DATA_W-1] ? (DATA_W'(0) - top_reg) : top_reg;
    assign dz_val = (ram_rdata == '0) ? '0 :
                    (ram_rdata[DATA_W-1] ? NEG_LIMIT : POS_LIMIT);

    // one 32x32 partial product per cycle
    assign pp_x    = iter_reg[0] ? opa_reg[DATA_W-1:HALF_W] : opa_reg[HALF_W-1:0];
    assign pp_y    = iter_reg[1] ? opb_reg[DATA_W-1:HALF_W] : opb_reg[HALF_W-1:0];
    assign pp_prod = pp_x * pp_y;
    assign pp_sh   = {1'b0, iter_reg[0]} + {1'b0, iter_reg[1]};

    always_comb
    begin
        case (psh_reg)
            2'd0:    pp_wide = WIDE_W'(prod_reg);
            2'd1:    pp_wide = WIDE_W'(prod_reg) << HALF_W;
            2'd2:    pp_wide = WIDE_W'(prod_reg) << DATA_W;
            default: pp_wide = '0;
        endcase
    end

    // restoring divide step: dividend bits leave the top, quotient bits enter below
    assign div_tmp      = {rem_reg, work_reg[QUO_W-1]};
    assign div_diff     = {1'b0, div_tmp} - {2'b00, opb_reg};
    assign div_ge       = ~div_diff[DATA_W+1];
    assign div_rem_next = div_ge ? div_diff[DATA_W-1:0] : div_tmp[DATA_W-1:0];

    // sign and clamp for multiply and divide results
    assign fin_wide  = is_div_reg ? work_reg : (work_reg >> FRAC_BITS);
    assign fin_hi_nz = |fin_wide[WIDE_W-1:DATA_W];
    assign fin_lo    = fin_wide[DATA_W-1:0];

    always_comb
    begin
        if (neg_reg)
        begin
            fin_sat = fin_hi_nz || (fin_lo > NEG_LIMIT);
            fin_val = fin_sat ? NEG_LIMIT : (DATA_W'(0) - fin_lo);
        end
        else
        begin
            fin_sat = fin_hi_nz || fin_lo[DATA_W-1];
            fin_val = fin_sat ? POS_LIMIT : fin_lo;
        end
    end

    // stack RAM port control
    assign ram_raddr = cnt_m2[PTR_W-1:0];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_m2[PTR_W-1:0];
        ram_wdata = fin_val;
        case (state_reg)
            S_DECODE:
            begin
                if (!halted && kind_reg == K_PUSH && count_reg < CNT_W'(STACK_DEPTH))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = count_reg[PTR_W-1:0];
                    ram_wdata = imm_reg;
                end
                else if (!halted && kind_reg == K_NEG && count_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_m1[PTR_W-1:0];
                    ram_wdata = add_res;
                end
            end
            S_FETCH:
            begin
                if (kind_reg == K_ADD || kind_reg == K_SUB)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = add_res;
                end
                else if (kind_reg == K_DIV && top_reg == '0)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = dz_val;
                end
            end
            S_FINISH:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    sce_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer, stack pointer, arithmetic registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            top_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // output taken; an output load in S_DONE sets it again instead
            if (res_valid_reg && !res_stall && state_reg != S_DONE)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        kind_reg  <= kind;
                        imm_reg   <= $unsigned(immediate);
                        sat_reg   <= 1'b0;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    state_reg <= S_DONE;
                    if (!halted)
                    begin
                        case (kind_reg)
                            K_PUSH:
                            begin
                                if (count_reg < CNT_W'(STACK_DEPTH))
                                begin
                                    top_reg   <= imm_reg;
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                                else if (err_reg == ST_OK)
                                begin
                                    err_reg <= ST_OVER;
                                end
                            end
                            K_NEG:
                            begin
                                if (count_reg == '0)
                                begin
                                    err_reg <= ST_UNDER;
                                end
                                else
                                begin
                                    top_reg <= add_res;
                                    sat_reg <= add_ovf;
                                end
                            end
                            K_ADD, K_SUB, K_MUL, K_DIV:
                            begin
                                if (count_reg < CNT_W'(2))
                                begin
                                    err_reg <= ST_UNDER;
                                end
                                else
                                begin
                                    state_reg <= S_FETCH;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_FETCH:
                begin
                    neg_reg  <= ram_rdata[DATA_W-1] ^ top_reg[DATA_W-1];
                    opb_reg  <= mag_b;
                    iter_reg <= '0;
                    case (kind_reg)
                        K_ADD, K_SUB:
                        begin
                            top_reg   <= add_res;
                            sat_reg   <= add_ovf;
                            count_reg <= cnt_m1;
                            state_reg <= S_DONE;
                        end
                        K_MUL:
                        begin
                            opa_reg    <= mag_a;
                            is_div_reg <= 1'b0;
                            work_reg   <= '0;
                            state_reg  <= S_MUL;
                        end
                        K_DIV:
                        begin
                            if (top_reg == '0)
                            begin
                                top_reg   <= dz_val;
                                sat_reg   <= 1'b1;
                                count_reg <= cnt_m1;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                is_div_reg <= 1'b1;
                                rem_reg    <= '0;
                                work_reg   <= WIDE_W'(mag_a) << FRAC_BITS;
                                state_reg  <= S_DIV;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_MUL:
                begin
                    // issue a partial product, accumulate the one before it
                    if (iter_reg < ITER_W'(MUL_STEPS))
                    begin
                        prod_reg <= pp_prod;
                        psh_reg  <= pp_sh;
                    end
                    if (iter_reg != '0)
                    begin
                        work_reg <= work_reg + pp_wide;
                    end
                    if (iter_reg == ITER_W'(MUL_STEPS))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        iter_reg <= iter_reg + ITER_W'(1);
                    end
                end
                S_DIV:
                begin
                    rem_reg              <= div_rem_next;
                    work_reg[QUO_W-1:0]  <= {work_reg[QUO_W-2:0], div_ge};
                    if (iter_reg == ITER_W'(QUO_W - 1))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        iter_reg <= iter_reg + ITER_W'(1);
                    end
                end
                S_FINISH:
                begin
                    top_reg   <= fin_val;
                    sat_reg   <= fin_sat;
                    count_reg <= cnt_m1;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!res_valid_reg || !res_stall)
                    begin
                        res_valid_reg <= 1'b1;
                        top_value_reg <= (count_reg != '0) ? top_reg : '0;
                        depth_reg     <= DEPTH_W'(count_reg);
                        status_reg    <= err_reg;
                        saturated_reg <= sat_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign top_value = $signed(top_value_reg);
    assign depth     = depth_reg;
    assign status    = status_reg;
    assign saturated = saturated_reg;

    // checks
    `SCE_ASSERT(a_count_bound, count_reg <= CNT_W'(STACK_DEPTH), "stack count beyond capacity")
    `SCE_ASSERT_NEXT(a_under_sticky, err_reg == ST_UNDER, err_reg == ST_UNDER, "underflow status cleared")
    `SCE_ASSERT_NEXT(a_halt_frozen, err_reg == ST_UNDER, $stable(count_reg) && $stable(top_reg), "stack moved while halted")
    `SCE_ASSERT(a_res_from_done, $rose(res_valid_reg) |-> $past(state_reg == S_DONE), "result raised outside output load")
    `SCE_ASSERT(a_count_source, !$stable(count_reg) |-> ($past(state_reg) == S_DECODE || $past(state_reg) == S_FETCH || $past(state_reg) == S_FINISH), "stack count changed in wrong state")

endmodule
`default_nettype wire
